### rtl/nfmsa_pkg.sv
// nfmsa_pkg: status and action codes, field widths and the command/status
// structs shared by the slot allocator controller, datapath and top level
// no dependencies
`default_nettype none

package nfmsa_pkg;

    localparam int STATUS_W   = 3;
    localparam int ADDR_W     = 32;
    localparam int SLOT_OUT_W = 10;
    localparam int ACT_W      = 2;
    localparam int FRAME_W    = 20;

    localparam logic [STATUS_W-1:0] ST_MAPPED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOWMEM   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOPAGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 3'd6;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd7;

    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MAP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UNMAP = 2'd2;

    localparam logic [ADDR_W-1:0] WINDOW_BASE_RESET = 32'hE000_0000;

    typedef struct packed {
        logic                clear;
        logic                latch;
        logic                check;
        logic                search_start;
        logic                search_run;
        logic                map_commit;
        logic                unmap_commit;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic unmap;
        logic present;
        logic high;
        logic ok;
        logic owned;
        logic found;
        logic exhausted;
    } dp_sts_t;

endpackage

`default_nettype wire

### rtl/nfmsa_ctrl.sv
// nfmsa_ctrl: sequencing state machine of the slot allocator
// depends on nfmsa_pkg for the command and status structs and status codes
`default_nettype none

module nfmsa_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    output nfmsa_pkg::dp_cmd_t   cmd,
    input  nfmsa_pkg::dp_sts_t   sts
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_OWN    = 3'd3;
    localparam logic [2:0] S_SEARCH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.present || !sts.high)
                begin
                    cmd.res_load = 1'b1;
                    if (sts.unmap)
                    begin
                        cmd.res_status = nfmsa_pkg::ST_IGNORED;
                    end
                    else if (!sts.present)
                    begin
                        cmd.res_status = nfmsa_pkg::ST_NOPAGE;
                    end
                    else
                    begin
                        cmd.res_status = nfmsa_pkg::ST_LOWMEM;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.check  = 1'b1;
                    state_next = S_OWN;
                end
            end
            S_OWN:
            begin
                if (sts.unmap)
                begin
                    cmd.res_load = 1'b1;
                    if (sts.owned)
                    begin
                        cmd.unmap_commit = 1'b1;
                        cmd.res_status   = nfmsa_pkg::ST_UNMAPPED;
                    end
                    else
                    begin
                        cmd.res_status = nfmsa_pkg::ST_IGNORED;
                    end
                    state_next = S_IDLE;
                end
                else if (sts.owned)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = nfmsa_pkg::ST_ALREADY;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.search_start = 1'b1;
                    state_next       = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (sts.found)
                begin
                    cmd.map_commit = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = sts.ok ? nfmsa_pkg::ST_MAPPED : nfmsa_pkg::ST_FAILED;
                    state_next     = S_IDLE;
                end
                else if (sts.exhausted)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = nfmsa_pkg::ST_FULL;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.search_run = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

### rtl/nfmsa_dp.sv
// nfmsa_dp: slot bitmap and owner memories, next-fit row scanner, ownership
// check, window base register and result registers
// depends on nfmsa_pkg for codes, widths and the command/status structs
`default_nettype none

module nfmsa_dp #(
    parameter int SLOT_COUNT = 1024,
    parameter int PAGE_SHIFT = 12,
    parameter int FRAME_BITS = 20
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  nfmsa_pkg::dp_cmd_t                    cmd,
    output nfmsa_pkg::dp_sts_t                    sts,
    input  wire                                   cfg_we,
    input  wire  [nfmsa_pkg::ADDR_W-1:0]          cfg_data,
    input  wire                                   command,
    input  wire                                   page_present,
    input  wire  [nfmsa_pkg::FRAME_W-1:0]         page_frame,
    input  wire                                   is_high_page,
    input  wire  [nfmsa_pkg::ADDR_W-1:0]          recorded_address,
    input  wire                                   table_update_ok,
    output logic                                  done,
    output logic [nfmsa_pkg::STATUS_W-1:0]        status,
    output logic [nfmsa_pkg::ADDR_W-1:0]          window_address,
    output logic [nfmsa_pkg::SLOT_OUT_W-1:0]      slot_index,
    output logic [nfmsa_pkg::ACT_W-1:0]           table_action
);

    localparam int SB   = $clog2(SLOT_COUNT);
    localparam int WW   = (SLOT_COUNT < 32) ? (1 << $clog2(SLOT_COUNT)) : 32;
    localparam int WB   = $clog2(WW);
    localparam int ROWS = (SLOT_COUNT + WW - 1) / WW;
    localparam int RB   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CB   = $clog2(ROWS + 2);
    localparam int FB   = (FRAME_BITS < nfmsa_pkg::FRAME_W) ? FRAME_BITS : nfmsa_pkg::FRAME_W;

    // memories
    logic [WW-1:0] used_mem  [ROWS];
    logic [FB-1:0] owner_mem [SLOT_COUNT];

    logic [nfmsa_pkg::ADDR_W-1:0] base_reg;

    // latched item
    logic                          unmap_reg;
    logic                          present_reg;
    logic                          high_reg;
    logic                          ok_reg;
    logic [FB-1:0]                 frame_reg;
    logic [nfmsa_pkg::ADDR_W-1:0]  rec_reg;

    // ownership check
    logic [nfmsa_pkg::ADDR_W:0]    diff;
    logic [nfmsa_pkg::ADDR_W-1:0]  offs;
    logic                          in_range_c;
    logic [SB-1:0]                 own_slot_c;
    logic [RB-1:0]                 own_row_c;
    logic [SB-1:0]                 own_slot_reg;
    logic                          in_range_reg;
    logic [RB-1:0]                 own_row;
    logic [WB-1:0]                 own_off;
    logic [FB-1:0]                 owner_rd_reg;

    // scanner
    logic [SB-1:0]                 hint_reg;
    logic [RB-1:0]                 hint_row;
    logic [WB-1:0]                 hint_off;
    logic [RB-1:0]                 srch_row_reg;
    logic [CB-1:0]                 issue_cnt_reg;
    logic                          issue_more;
    logic [RB-1:0]                 rd_row_reg;
    logic                          rd_first_reg;
    logic                          rd_last_reg;
    logic                          rd_valid_reg;
    logic [WW-1:0]                 used_rd_reg;
    logic [WW-1:0]                 avail;
    logic [WW-1:0]                 lowest;
    logic [WB-1:0]                 fbit;
    logic [SB-1:0]                 fnd_slot;

    // clearing pass
    logic [RB-1:0]                 clr_cnt_reg;
    logic                          clr_done;

    // bitmap port
    logic                          used_we;
    logic [RB-1:0]                 used_waddr;
    logic [WW-1:0]                 used_wdata;
    logic                          used_re;
    logic [RB-1:0]                 used_raddr;
    logic                          owner_we;

    // result stage
    logic                          res_pend_reg;
    logic [nfmsa_pkg::STATUS_W-1:0] res_status_reg;
    logic [SB-1:0]                 res_slot_reg;
    logic                          has_slot;
    logic [SB+PAGE_SHIFT-1:0]      slot_sh;
    logic                          done_reg;
    logic [nfmsa_pkg::STATUS_W-1:0] status_reg;
    logic [nfmsa_pkg::ADDR_W-1:0]  window_address_reg;
    logic [nfmsa_pkg::SLOT_OUT_W-1:0] slot_index_reg;
    logic [nfmsa_pkg::ACT_W-1:0]   table_action_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= nfmsa_pkg::WINDOW_BASE_RESET;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            unmap_reg   <= command;
            present_reg <= page_present;
            high_reg    <= is_high_page;
            ok_reg      <= table_update_ok;
            frame_reg   <= page_frame[FB-1:0];
            rec_reg     <= recorded_address;
        end
    end

    // recorded address back to a slot
    always_comb
    begin
        diff       = {1'b0, rec_reg} - {1'b0, base_reg};
        offs       = diff[nfmsa_pkg::ADDR_W-1:0] >> PAGE_SHIFT;
        in_range_c = (rec_reg != '0) && !diff[nfmsa_pkg::ADDR_W]
                     && (offs < nfmsa_pkg::ADDR_W'(SLOT_COUNT));
        own_slot_c = SB'(offs);
        own_row_c  = RB'(own_slot_c >> WB);
    end

    assign own_row  = RB'(own_slot_reg >> WB);
    assign own_off  = own_slot_reg[WB-1:0];
    assign hint_row = RB'(hint_reg >> WB);
    assign hint_off = hint_reg[WB-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            own_slot_reg <= own_slot_c;
            in_range_reg <= in_range_c;
        end
    end

    // scanner control
    assign issue_more = (issue_cnt_reg < CB'(ROWS + 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            srch_row_reg  <= '0;
            hint_reg      <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.clear && !clr_done)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.search_start)
            begin
                srch_row_reg  <= hint_row;
                issue_cnt_reg <= '0;
                rd_valid_reg  <= 1'b0;
            end
            else if (cmd.search_run && issue_more)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
                rd_valid_reg  <= 1'b1;
                srch_row_reg  <= (srch_row_reg == RB'(ROWS - 1)) ? '0 : srch_row_reg + 1'b1;
            end
            else
            begin
                rd_valid_reg <= 1'b0;
            end
            if (cmd.map_commit)
            begin
                hint_reg <= (fnd_slot == SB'(SLOT_COUNT - 1)) ? '0 : fnd_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search_run && issue_more)
        begin
            rd_row_reg   <= srch_row_reg;
            rd_first_reg <= (issue_cnt_reg == '0);
            rd_last_reg  <= (issue_cnt_reg == CB'(ROWS));
        end
    end

    assign clr_done = (clr_cnt_reg == RB'(ROWS - 1));

    // free slots of the row just read, in search order
    always_comb
    begin
        for (int i = 0; i < WW; i++)
        begin
            avail[i] = !used_rd_reg[i] && ((int'(rd_row_reg) * WW + i) < SLOT_COUNT);
            if (rd_first_reg)
            begin
                avail[i] = avail[i] && (i >= int'(hint_off));
            end
            else if (rd_last_reg)
            begin
                avail[i] = avail[i] && (i < int'(hint_off));
            end
        end
        lowest = avail & (~avail + WW'(1));
        fbit   = '0;
        for (int i = 0; i < WW; i++)
        begin
            if (lowest[i])
            begin
                fbit = fbit | WB'(i);
            end
        end
        fnd_slot = SB'({rd_row_reg, fbit});
    end

    // bitmap and owner memories
    always_comb
    begin
        used_re    = cmd.check || (cmd.search_run && issue_more);
        used_raddr = cmd.check ? own_row_c : srch_row_reg;
        used_we    = 1'b0;
        used_waddr = clr_cnt_reg;
        used_wdata = '0;
        owner_we   = cmd.map_commit && ok_reg;
        if (cmd.clear)
        begin
            used_we = 1'b1;
        end
        else if (owner_we)
        begin
            used_we    = 1'b1;
            used_waddr = rd_row_reg;
            used_wdata = used_rd_reg | lowest;
        end
        else if (cmd.unmap_commit)
        begin
            used_we    = 1'b1;
            used_waddr = own_row;
            used_wdata = used_rd_reg & ~(WW'(1) << own_off);
        end
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
        if (used_re)
        begin
            used_rd_reg <= used_mem[used_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_mem[fnd_slot] <= frame_reg;
        end
        if (cmd.check)
        begin
            owner_rd_reg <= owner_mem[own_slot_c];
        end
    end

    always_comb
    begin
        sts           = '0;
        sts.clr_done  = clr_done;
        sts.unmap     = unmap_reg;
        sts.present   = present_reg;
        sts.high      = high_reg;
        sts.ok        = ok_reg;
        sts.owned     = in_range_reg && used_rd_reg[own_off] && (owner_rd_reg == frame_reg);
        sts.found     = rd_valid_reg && (avail != '0);
        sts.exhausted = rd_valid_reg && rd_last_reg && (avail == '0);
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            res_pend_reg <= cmd.res_load;
            done_reg     <= res_pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= (cmd.res_status == nfmsa_pkg::ST_MAPPED
                               || cmd.res_status == nfmsa_pkg::ST_FAILED) ? fnd_slot
                                                                           : own_slot_reg;
        end
    end

    assign has_slot = res_status_reg inside {nfmsa_pkg::ST_MAPPED, nfmsa_pkg::ST_FAILED,
                                             nfmsa_pkg::ST_ALREADY, nfmsa_pkg::ST_UNMAPPED};
    assign slot_sh  = {res_slot_reg, {PAGE_SHIFT{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (res_pend_reg)
        begin
            status_reg         <= res_status_reg;
            window_address_reg <= has_slot ? base_reg + nfmsa_pkg::ADDR_W'(slot_sh) : '0;
            slot_index_reg     <= has_slot ? nfmsa_pkg::SLOT_OUT_W'(res_slot_reg) : '0;
            case (res_status_reg)
                nfmsa_pkg::ST_MAPPED,
                nfmsa_pkg::ST_FAILED:   table_action_reg <= nfmsa_pkg::ACT_MAP;
                nfmsa_pkg::ST_UNMAPPED: table_action_reg <= nfmsa_pkg::ACT_UNMAP;
                default:                table_action_reg <= nfmsa_pkg::ACT_NONE;
            endcase
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign window_address = window_address_reg;
    assign slot_index     = slot_index_reg;
    assign table_action   = table_action_reg;

endmodule

`default_nettype wire

### rtl/next_fit_map_slot_allocator_top.sv
// next_fit_map_slot_allocator_top: next-fit window slot allocator, map and unmap
// depends on nfmsa_pkg, nfmsa_ctrl and nfmsa_dp
//
// channel   direction  handshake            payload
// request   in         start & !busy        command, page_present, page_frame,
//                                           is_high_page, recorded_address,
//                                           table_update_ok
// result    out        done (one cycle)     status, window_address, slot_index,
//                                           table_action
// config    in         cfg_valid&cfg_ready  cfg_data (window_base)
//
// an item ends at the page check (null or low-memory page), at the owned-slot check,
// or after a map search over the bitmap rows (32 slots each), starting at the hint row
// and wrapping round back to it; the single bitmap read port sets the scan rate,
// one row per cycle; done rises in the cycle after busy falls
// after reset a clearing pass over every bitmap row holds busy high
// the receiver cannot stall; cfg_ready is always high
`default_nettype none

module next_fit_map_slot_allocator_top #(
    parameter int SLOT_COUNT = 1024,
    parameter int PAGE_SHIFT = 12,
    parameter int FRAME_BITS = 20
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire                                   command,
    input  wire                                   page_present,
    input  wire  [nfmsa_pkg::FRAME_W-1:0]         page_frame,
    input  wire                                   is_high_page,
    input  wire  [nfmsa_pkg::ADDR_W-1:0]          recorded_address,
    input  wire                                   table_update_ok,
    output logic                                  done,
    output logic [nfmsa_pkg::STATUS_W-1:0]        status,
    output logic [nfmsa_pkg::ADDR_W-1:0]          window_address,
    output logic [nfmsa_pkg::SLOT_OUT_W-1:0]      slot_index,
    output logic [nfmsa_pkg::ACT_W-1:0]           table_action,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [nfmsa_pkg::ADDR_W-1:0]          cfg_data
);

    nfmsa_pkg::dp_cmd_t cmd;
    nfmsa_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    nfmsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    nfmsa_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .PAGE_SHIFT (PAGE_SHIFT),
        .FRAME_BITS (FRAME_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .command          (command),
        .page_present     (page_present),
        .page_frame       (page_frame),
        .is_high_page     (is_high_page),
        .recorded_address (recorded_address),
        .table_update_ok  (table_update_ok),
        .done             (done),
        .status           (status),
        .window_address   (window_address),
        .slot_index       (slot_index),
        .table_action     (table_action)
    );

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(busy))
        else $error("result strobe without an idle cycle before it");

    a_map_action: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == nfmsa_pkg::ST_MAPPED || status == nfmsa_pkg::ST_FAILED))
        |-> (table_action == nfmsa_pkg::ACT_MAP))
        else $error("map result without map action");

    a_no_action_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_action == nfmsa_pkg::ACT_NONE && status != nfmsa_pkg::ST_ALREADY)
        |-> (window_address == '0 && slot_index == '0))
        else $error("result without slot carries an address");
`endif

endmodule

`default_nettype wire
